// File: hdl/fasr_pkg.sv
// Package for fraction_add_sub_reduce: controller states, command/status structs, divider selects.
// No dependencies.
package fasr_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_PREP,
      ST_GCD_START,
      ST_GCD_RUN,
      ST_DIVN_START,
      ST_DIVN_RUN,
      ST_DIVD_START,
      ST_DIVD_RUN,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic prep;
      logic div_start;
      logic [1:0] div_sel;   // 0 gcd remainder, 1 numerator by g, 2 denominator by g
      logic gcd_swap;
      logic fin_n;
      logic fin_d;
      logic out_set;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic y_zero;
      logic special;
      logic out_busy;
   } status_type;

   localparam logic [1:0] SelGcd = 2'd0;
   localparam logic [1:0] SelNum = 2'd1;
   localparam logic [1:0] SelDen = 2'd2;

endpackage

// File: hdl/fasr_ctrl.sv
// Controller state machine for fraction_add_sub_reduce.
// Depends on fasr_pkg.
module fasr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_fire,
   output logic                 in_ready,
   input  fasr_pkg::status_type sts,
   output fasr_pkg::cmd_type    cmd
);

   fasr_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= fasr_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      in_ready = 1'b0;
      unique case (state_ff)
         fasr_pkg::ST_IDLE: begin
            in_ready = 1'b1;
            if (in_fire) begin
               cmd.load = 1'b1;
               state_in = fasr_pkg::ST_MUL;
            end
         end
         fasr_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = fasr_pkg::ST_PREP;
         end
         fasr_pkg::ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = sts.special ? fasr_pkg::ST_OUT : fasr_pkg::ST_GCD_START;
         end
         fasr_pkg::ST_GCD_START: begin
            if (sts.y_zero) state_in = fasr_pkg::ST_DIVN_START;
            else begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = fasr_pkg::SelGcd;
               state_in      = fasr_pkg::ST_GCD_RUN;
            end
         end
         fasr_pkg::ST_GCD_RUN: begin
            cmd.div_sel = fasr_pkg::SelGcd;
            if (sts.div_done) begin
               cmd.gcd_swap = 1'b1;
               state_in     = fasr_pkg::ST_GCD_START;
            end
         end
         fasr_pkg::ST_DIVN_START: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = fasr_pkg::SelNum;
            state_in      = fasr_pkg::ST_DIVN_RUN;
         end
         fasr_pkg::ST_DIVN_RUN: begin
            cmd.div_sel = fasr_pkg::SelNum;
            if (sts.div_done) begin
               cmd.fin_n = 1'b1;
               state_in  = fasr_pkg::ST_DIVD_START;
            end
         end
         fasr_pkg::ST_DIVD_START: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = fasr_pkg::SelDen;
            state_in      = fasr_pkg::ST_DIVD_RUN;
         end
         fasr_pkg::ST_DIVD_RUN: begin
            cmd.div_sel = fasr_pkg::SelDen;
            if (sts.div_done) begin
               cmd.fin_d = 1'b1;
               state_in  = fasr_pkg::ST_OUT;
            end
         end
         fasr_pkg::ST_OUT: begin
            if (!sts.out_busy) begin
               cmd.out_set = 1'b1;
               state_in    = fasr_pkg::ST_IDLE;
            end
         end
         default: state_in = fasr_pkg::ST_IDLE;
      endcase
   end

endmodule

// File: hdl/fasr_datapath.sv
// Datapath for fraction_add_sub_reduce: products, shared restoring divider, output register.
// Depends on fasr_pkg.
module fasr_datapath #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  fasr_pkg::cmd_type           cmd,
   output fasr_pkg::status_type        sts,
   input  logic                        in_cmd,
   input  logic [OPERAND_WIDTH-1:0]    in_a_num,
   input  logic [OPERAND_WIDTH-1:0]    in_a_den,
   input  logic [OPERAND_WIDTH-1:0]    in_b_num,
   input  logic [OPERAND_WIDTH-1:0]    in_b_den,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [2*OPERAND_WIDTH:0]    out_num,
   output logic [2*OPERAND_WIDTH-2:0]  out_den,
   output logic                        out_err
);

   localparam int PW = 2 * OPERAND_WIDTH;   // product width
   localparam int MW = PW + 1;              // magnitude width of the sum
   localparam int CW = $clog2(MW + 1);

   logic                     sub_ff;
   logic [OPERAND_WIDTH-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic signed [PW-1:0]     p1_ff, p2_ff, pd_ff;
   logic [MW-1:0]            x_ff, y_ff, nmag_ff, dmag_ff;
   logic                     neg_ff, err_ff, zero_ff;

   // shared divider
   logic [MW-1:0] q_ff, rem_ff, dvs_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;

   logic          ov_ff;
   logic [MW-1:0] on_ff;
   logic [PW-2:0] od_ff;
   logic          oe_ff;

   logic signed [MW-1:0] n_s, d_s;
   logic [MW:0]          trial;
   logic [MW-1:0]        dvd_sel;
   logic [MW-1:0]        q_fin;
   logic [MW-1:0]        rn;

   always_comb begin
      n_s = sub_ff ? ($signed({p1_ff[PW-1], p1_ff}) - $signed({p2_ff[PW-1], p2_ff}))
                   : ($signed({p1_ff[PW-1], p1_ff}) + $signed({p2_ff[PW-1], p2_ff}));
      d_s = $signed({pd_ff[PW-1], pd_ff});
      trial = {rem_ff, q_ff[MW-1]} - {1'b0, dvs_ff};
      case (cmd.div_sel)
         fasr_pkg::SelGcd: dvd_sel = x_ff;
         fasr_pkg::SelNum: dvd_sel = nmag_ff;
         default:          dvd_sel = dmag_ff;
      endcase
      // quotient including the bit of the step that ends on this edge
      q_fin = {q_ff[MW-2:0], ~trial[MW]};
      rn = neg_ff ? (~q_fin + MW'(1)) : q_fin;
   end

   assign sts.div_done = busy_ff && (cnt_ff == '0);
   assign sts.y_zero   = (y_ff == '0);
   assign sts.special  = err_ff || (n_s == '0);
   assign sts.out_busy = ov_ff && !out_ready;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sub_ff <= in_cmd;
         an_ff  <= in_a_num;
         ad_ff  <= in_a_den;
         bn_ff  <= in_b_num;
         bd_ff  <= in_b_den;
      end
      if (cmd.mul) begin
         p1_ff   <= $signed(an_ff) * $signed(bd_ff);
         p2_ff   <= $signed(bn_ff) * $signed(ad_ff);
         pd_ff   <= $signed(ad_ff) * $signed(bd_ff);
         err_ff  <= (ad_ff == '0) || (bd_ff == '0);
      end
      if (cmd.prep) begin
         zero_ff <= (n_s == '0);
         neg_ff  <= n_s[MW-1] ^ d_s[MW-1];
         nmag_ff <= n_s[MW-1] ? MW'(-n_s) : MW'(n_s);
         dmag_ff <= d_s[MW-1] ? MW'(-d_s) : MW'(d_s);
         x_ff    <= n_s[MW-1] ? MW'(-n_s) : MW'(n_s);
         y_ff    <= d_s[MW-1] ? MW'(-d_s) : MW'(d_s);
      end
      if (cmd.gcd_swap) begin
         x_ff <= y_ff;
         y_ff <= trial[MW] ? {rem_ff[MW-2:0], q_ff[MW-1]} : trial[MW-1:0];
      end
      if (cmd.fin_n) nmag_ff <= rn;
   end

   // restoring divider, one quotient bit per cycle; divisor is x (gcd) for reductions
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (cmd.div_start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CW'(MW - 1);
      end else if (busy_ff) begin
         if (cnt_ff == '0) busy_ff <= 1'b0;
         else              cnt_ff  <= cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         q_ff   <= dvd_sel;
         rem_ff <= '0;
         dvs_ff <= (cmd.div_sel == fasr_pkg::SelGcd) ? y_ff : x_ff;
      end else if (busy_ff && !(cnt_ff == '0)) begin
         q_ff   <= {q_ff[MW-2:0], ~trial[MW]};
         rem_ff <= trial[MW] ? {rem_ff[MW-2:0], q_ff[MW-1]} : trial[MW-1:0];
      end else if (busy_ff) begin
         q_ff   <= {q_ff[MW-2:0], ~trial[MW]};
         rem_ff <= trial[MW] ? {rem_ff[MW-2:0], q_ff[MW-1]} : trial[MW-1:0];
      end
   end

   // gcd_swap reads the final remainder from the last step's trial; it fires
   // on the same edge as the last step, so the trial is still current.

   always_ff @(posedge clock) begin
      if (reset) ov_ff <= 1'b0;
      else if (cmd.out_set) ov_ff <= 1'b1;
      else if (out_ready) ov_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_set) begin
         oe_ff <= err_ff;
         if (err_ff) begin
            on_ff <= '0;
            od_ff <= '0;
         end else if (zero_ff) begin
            on_ff <= '0;
            od_ff <= (PW-1)'(1);
         end else begin
            on_ff <= nmag_ff;
            od_ff <= q_ff[PW-2:0];
         end
      end
   end

   assign out_valid = ov_ff;
   assign out_num   = on_ff;
   assign out_den   = od_ff;
   assign out_err   = oe_ff;

endmodule

// File: hdl/fraction_add_sub_reduce.sv
// Top level of fraction_add_sub_reduce: stream ports, controller and datapath.
// Depends on fasr_pkg, fasr_ctrl, fasr_datapath.
//
// Adds or subtracts two signed fractions and reduces the result to lowest terms.
// req_ carries one operation word; rsp_ returns one result word per request.
// Flow: capture, three products, sign/magnitude prep, Euclid gcd with each
// remainder from a shared bit-serial restoring divider (a start state, then
// a run state for each step), then two exact divisions by the gcd.
// The time from accept to rsp_tvalid grows with the number of Euclid steps,
// so long gcd chains take longer.
// A zero denominator or a zero numerator of the sum skips the divider.
// One request at a time: req_tready is high only while idle.
// The result sits in an output register; while rsp_tready is low it holds,
// and the next request is accepted as soon as the previous result is loaded.
// Synchronous reset empties the output register and returns to idle.
module fraction_add_sub_reduce #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // cmd, a_num, a_den, b_num, b_den from bit 0 up, zero padded
   input  logic [((4*OPERAND_WIDTH+1+7)/8)*8-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // res_num, res_den, zero_den_error from bit 0 up, zero padded
   output logic [((4*OPERAND_WIDTH+1+7)/8)*8-1:0] rsp_tdata
);

   localparam int RspWidth = ((4*OPERAND_WIDTH+1+7)/8)*8;

   fasr_pkg::cmd_type    cmd;
   fasr_pkg::status_type sts;
   logic                 in_fire;
   logic [2*OPERAND_WIDTH:0]   num;
   logic [2*OPERAND_WIDTH-2:0] den;
   logic                 err;

   assign in_fire = req_tvalid && req_tready;

   fasr_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_fire  (in_fire),
      .in_ready (req_tready),
      .sts      (sts),
      .cmd      (cmd)
   );

   fasr_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .in_cmd    (req_tdata[0]),
      .in_a_num  (req_tdata[1 +: OPERAND_WIDTH]),
      .in_a_den  (req_tdata[1+OPERAND_WIDTH +: OPERAND_WIDTH]),
      .in_b_num  (req_tdata[1+2*OPERAND_WIDTH +: OPERAND_WIDTH]),
      .in_b_den  (req_tdata[1+3*OPERAND_WIDTH +: OPERAND_WIDTH]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_num   (num),
      .out_den   (den),
      .out_err   (err)
   );

   assign rsp_tdata = RspWidth'({err, den, num});

endmodule
